FILE: rtl/core/rbd_pkg.sv
// shared types, constants and helpers for the ring buffer deque
package rbd_pkg;

	localparam int CAPACITY    = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam int ACTION_W    = 3;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 4;
	localparam int DOUT_W      = 32;
	localparam int COUNT_W     = 5;
	localparam int STATUS_W    = 2;
	localparam int SUM_W       = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 104;
	localparam int RES_W       = 3 * DOUT_W + COUNT_W + STATUS_W;

	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_READ       = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef enum logic [6:0] {
		K_PUSH_FRONT = 7'b0000001,
		K_PUSH_BACK  = 7'b0000010,
		K_POP_FRONT  = 7'b0000100,
		K_POP_BACK   = 7'b0001000,
		K_READ       = 7'b0010000,
		K_CLEAR      = 7'b0100000,
		K_NOP        = 7'b1000000
	} cmd_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [DATA_WIDTH-1:0] value;
		logic [POS_W-1:0]      position;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  entry_count;
		logic [DOUT_W-1:0]   back_value;
		logic [DOUT_W-1:0]   front_value;
		logic [DOUT_W-1:0]   data_out;
	} result_t;

	function automatic logic [DATA_WIDTH-1:0] to_data(input logic [VALUE_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [DOUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] w;
		w = 64'(d);
		return w[DOUT_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] p);
		return (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
	endfunction

endpackage

FILE: rtl/core/rbd_front.sv
// input side: takes beats and decodes the action into a command
module rbd_front import rbd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // action, value, position
	output cmd_t                  cmd,
	output logic                  cmd_valid,
	input  logic                  cmd_ready
);

	action_t   action;
	cmd_kind_t kind;
	logic      seen_q;

	assign action = action_t'(s_axis_tdata[ACTION_W-1:0]);

	always_comb begin
		unique case (action)
			ACT_PUSH_FRONT: kind = K_PUSH_FRONT;
			ACT_PUSH_BACK:  kind = K_PUSH_BACK;
			ACT_POP_FRONT:  kind = K_POP_FRONT;
			ACT_POP_BACK:   kind = K_POP_BACK;
			ACT_READ:       kind = K_READ;
			ACT_CLEAR:      kind = K_CLEAR;
			default:        kind = K_NOP;
		endcase
	end

	// hold off input until the release of reset has been registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign cmd.kind     = kind;
	assign cmd.value    = to_data(s_axis_tdata[ACTION_W +: VALUE_W]);
	assign cmd.position = s_axis_tdata[ACTION_W + VALUE_W +: POS_W];
	assign cmd_valid    = s_axis_tvalid && seen_q;
	assign s_axis_tready = cmd_ready && seen_q;

endmodule

FILE: rtl/core/rbd_cmd_fifo.sv
// short command queue between decode and execution
module rbd_cmd_fifo import rbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t in_cmd,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t out_cmd,
	output logic out_valid,
	input  logic out_ready
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_PTR_W:0]   fill_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = (fill_q != (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/rbd_exec.sv
// execution side: entry store, pointers, end values and result register
module rbd_exec import rbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	output result_t res,
	output logic    res_valid,
	input  logic    res_ready
);

	typedef enum logic [1:0] {
		EX_IDLE = 2'b01,
		EX_WAIT = 2'b10
	} exec_state_t;

	exec_state_t           state_q, state_n;
	logic [IDX_W-1:0]      head_q, head_n;
	logic [IDX_W-1:0]      tail_q, tail_n;
	logic [CNT_W-1:0]      count_q, count_n;
	logic [DATA_WIDTH-1:0] front_q, front_n;
	logic [DATA_WIDTH-1:0] back_q, back_n;
	cmd_kind_t             pend_kind_q, pend_kind_n;
	logic [DATA_WIDTH-1:0] pop_data_q, pop_data_n;
	result_t               res_q;
	logic                  res_valid_q;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  wr_en, rd_en;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	logic                  slot_free, issue, finish, load_res;
	logic [DATA_WIDTH-1:0] data_n;
	status_t               status_n;
	logic [SUM_W-1:0]      slot_sum;

	assign slot_free = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == EX_IDLE) && slot_free;
	assign issue     = cmd_valid && cmd_ready;
	assign finish    = (state_q == EX_WAIT) && slot_free;

	always_comb begin
		slot_sum = SUM_W'(head_q) + SUM_W'(cmd.position);
		if (slot_sum >= SUM_W'(CAPACITY)) begin
			slot_sum = slot_sum - SUM_W'(CAPACITY);
		end
	end

	always_comb begin
		state_n     = state_q;
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		front_n     = front_q;
		back_n      = back_q;
		pend_kind_n = pend_kind_q;
		pop_data_n  = pop_data_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = cmd.value;
		rd_en       = 1'b0;
		rd_addr     = '0;
		load_res    = 1'b0;
		data_n      = '0;
		status_n    = STAT_OK;

		if (issue) begin
			load_res = 1'b1;
			case (cmd.kind) inside
				K_PUSH_FRONT, K_PUSH_BACK: begin
					if (count_q == CNT_W'(CAPACITY)) begin
						status_n = STAT_FULL;
					end else if (count_q == '0) begin
						head_n  = '0;
						tail_n  = '0;
						wr_en   = 1'b1;
						wr_addr = '0;
						count_n = CNT_W'(1);
						front_n = cmd.value;
						back_n  = cmd.value;
					end else if (cmd.kind == K_PUSH_FRONT) begin
						head_n  = idx_prev(head_q);
						wr_en   = 1'b1;
						wr_addr = idx_prev(head_q);
						count_n = count_q + 1'b1;
						front_n = cmd.value;
					end else begin
						tail_n  = idx_next(tail_q);
						wr_en   = 1'b1;
						wr_addr = idx_next(tail_q);
						count_n = count_q + 1'b1;
						back_n  = cmd.value;
					end
				end
				K_POP_FRONT, K_POP_BACK: begin
					if (count_q == '0) begin
						status_n = STAT_EMPTY;
					end else begin
						data_n  = (cmd.kind == K_POP_FRONT) ? front_q : back_q;
						count_n = count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							head_n = '0;
							tail_n = '0;
						end else begin
							// new end value is read from the store into a register and taken up in the wait state
							load_res    = 1'b0;
							state_n     = EX_WAIT;
							pend_kind_n = cmd.kind;
							pop_data_n  = data_n;
							rd_en       = 1'b1;
							if (cmd.kind == K_POP_FRONT) begin
								head_n  = idx_next(head_q);
								rd_addr = idx_next(head_q);
							end else begin
								tail_n  = idx_prev(tail_q);
								rd_addr = idx_prev(tail_q);
							end
						end
					end
				end
				K_READ: begin
					if (32'(cmd.position) >= 32'(count_q)) begin
						status_n = STAT_RANGE;
					end else begin
						load_res    = 1'b0;
						state_n     = EX_WAIT;
						pend_kind_n = K_READ;
						rd_en       = 1'b1;
						rd_addr     = slot_sum[IDX_W-1:0];
					end
				end
				K_CLEAR: begin
					head_n  = '0;
					tail_n  = '0;
					count_n = '0;
				end
				default: begin
				end
			endcase
		end else if (finish) begin
			load_res = 1'b1;
			state_n  = EX_IDLE;
			case (pend_kind_q) inside
				K_POP_FRONT: begin
					front_n = rd_data_q;
					data_n  = pop_data_q;
				end
				K_POP_BACK: begin
					back_n = rd_data_q;
					data_n = pop_data_q;
				end
				default: begin
					data_n = rd_data_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		front_q    <= front_n;
		back_q     <= back_n;
		pop_data_q <= pop_data_n;
		if (load_res) begin
			res_q.data_out    <= to_out(data_n);
			res_q.front_value <= (count_n == '0) ? '0 : to_out(front_n);
			res_q.back_value  <= (count_n == '0) ? '0 : to_out(back_n);
			res_q.entry_count <= COUNT_W'(count_n);
			res_q.status      <= status_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EX_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pend_kind_q <= K_NOP;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			head_q      <= head_n;
			tail_q      <= tail_n;
			count_q     <= count_n;
			pend_kind_q <= pend_kind_n;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

FILE: rtl/core/ring_buffer_deque_top.sv
// top level of the ring buffer deque
// A double-ended queue of 16 words in a circular store. Each input beat carries an action
// (push front or back, pop front or back, read at a position from the front, clear) and
// produces exactly one output beat with the popped or read word, the front and back words
// after the step, the entry count and a status. A two-beat command queue sits between the
// decoder and the execution unit. Push, clear, refused actions and unused codes complete
// on issue in the execution unit; a pop that leaves entries behind and a read in range
// pass through a wait state, since the synchronous store read that fetches the new end word
// or the addressed word is registered before use. A finished result waits in the output
// register while the next command is already queued.
module ring_buffer_deque_top import rbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // action, value, position
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // data_out, front_value, back_value, entry_count, status
);

	cmd_t    dec_cmd, q_cmd;
	logic    dec_valid, dec_ready;
	logic    q_valid, q_ready;
	result_t res;

	rbd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cmd           (dec_cmd),
		.cmd_valid     (dec_valid),
		.cmd_ready     (dec_ready)
	);

	rbd_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (dec_cmd),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.out_cmd   (q_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready)
	);

	rbd_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.entry_count <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status == STAT_FULL |-> res.entry_count == COUNT_W'(CAPACITY))
		else $error("full status while not full");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status == STAT_EMPTY |-> res.entry_count == '0 && res.data_out == '0)
		else $error("empty status with entries or data");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.entry_count == '0 |-> res.front_value == '0 && res.back_value == '0)
		else $error("end values not zero when empty");

endmodule
